// ===== hw/rtl/vector_reflect_bounce_macros.svh =====
// ----------------------------------------------------------------------------
// vector_reflect_bounce assertion macros
// Short forms for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFLECT_BOUNCE_MACROS_SVH
`define VECTOR_REFLECT_BOUNCE_MACROS_SVH

// Same-cycle implication
`define VRB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vrb same-cycle check failed");

// Next-cycle implication
`define VRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vrb next-cycle check failed");

`endif

// ===== hw/rtl/vrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrb_pkg
// Shared constants and types of the vector reflection pipeline.
// ----------------------------------------------------------------------------
package vrb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DAMP_W    = 17;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd65536;

  // Register map: one register, index taken from paddr[2]
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_DAMPING = 1'b0;

  // Division geometry: 97-bit numerator, 63 quotient bits, 64-bit divisor
  localparam int NUM_W  = 97;
  localparam int QBITS  = 63;
  localparam int HEAD_W = NUM_W - QBITS;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  // Sideband that rides along the divider
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0]       tp_neg;
    logic [2:0]       ovf;
    logic             bounce;
    logic             zero;
  } side_t;

endpackage

// ===== hw/rtl/vrb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrb_if
// Valid/ready channels for the vector and result beats.
// ----------------------------------------------------------------------------
interface vrb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] ax;
  logic [31:0] ay;
  logic [31:0] az;
  logic [31:0] nx;
  logic [31:0] ny;
  logic [31:0] nz;
  logic        bounce;

  modport source (output valid, ax, ay, az, nx, ny, nz, bounce, input ready);
  modport sink   (input valid, ax, ay, az, nx, ny, nz, bounce, output ready);
endinterface

interface vrb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rx;
  logic [31:0] ry;
  logic [31:0] rz;
  logic [1:0]  status;

  modport source (output valid, rx, ry, rz, status, input ready);
  modport sink   (input valid, rx, ry, rz, status, output ready);
endinterface

// ===== hw/rtl/vrb_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrb_divider
// Three-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vrb_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [63:0]                        s,
  input  logic [2:0][63:0]                   rem0,
  input  logic [2:0][vrb_pkg::QBITS-1:0]     low,
  input  vrb_pkg::side_t                     side_in,
  output logic                               out_valid,
  output logic [2:0][vrb_pkg::QBITS-1:0]     q,
  output vrb_pkg::side_t                     side_out
);

  logic [vrb_pkg::QBITS-1:0]          st_v;
  logic [63:0]                        st_s    [vrb_pkg::QBITS];
  logic [2:0][63:0]                   st_r    [vrb_pkg::QBITS];
  logic [2:0][vrb_pkg::QBITS-1:0]     st_l    [vrb_pkg::QBITS];
  logic [2:0][vrb_pkg::QBITS-1:0]     st_q    [vrb_pkg::QBITS];
  vrb_pkg::side_t                     st_side [vrb_pkg::QBITS];

  for (genvar k = 0; k < vrb_pkg::QBITS; k++) begin : g_stage
    logic                           v_i;
    logic [63:0]                    s_i;
    logic [2:0][63:0]               r_i;
    logic [2:0][vrb_pkg::QBITS-1:0] l_i;
    logic [2:0][vrb_pkg::QBITS-1:0] q_i;
    vrb_pkg::side_t                 sd_i;
    logic [2:0][63:0]               r_n;
    logic [2:0][vrb_pkg::QBITS-1:0] l_n;
    logic [2:0][vrb_pkg::QBITS-1:0] q_n;

    if (k == 0) begin : g_first
      assign v_i  = in_valid;
      assign s_i  = s;
      assign r_i  = rem0;
      assign l_i  = low;
      assign q_i  = '0;
      assign sd_i = side_in;
    end else begin : g_next
      assign v_i  = st_v[k-1];
      assign s_i  = st_s[k-1];
      assign r_i  = st_r[k-1];
      assign l_i  = st_l[k-1];
      assign q_i  = st_q[k-1];
      assign sd_i = st_side[k-1];
    end

    // Shift in the next numerator bit and try one subtract per lane
    always_comb begin
      logic [64:0] t;
      logic        ge;
      for (int j = 0; j < 3; j++) begin
        t = {r_i[j], l_i[j][vrb_pkg::QBITS-1]};
        ge = (t >= {1'b0, s_i});
        r_n[j] = ge ? 64'(t - {1'b0, s_i}) : t[63:0];
        l_n[j] = {l_i[j][vrb_pkg::QBITS-2:0], 1'b0};
        q_n[j] = {q_i[j][vrb_pkg::QBITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else if (en) begin
        st_v[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_s[k]    <= s_i;
        st_r[k]    <= r_n;
        st_l[k]    <= l_n;
        st_q[k]    <= q_n;
        st_side[k] <= sd_i;
      end
    end
  end

  assign out_valid = st_v[vrb_pkg::QBITS-1];
  assign q         = st_q[vrb_pkg::QBITS-1];
  assign side_out  = st_side[vrb_pkg::QBITS-1];

endmodule

// ===== hw/rtl/vector_reflect_bounce.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the buffer has room; the 63-stage divider likewise.
// A two-entry output buffer decouples the sides; ready depends on buffer fill only.
// Reset (rst, synchronous): all valid bits and the buffer clear, damping returns to 1.0.
// ----------------------------------------------------------------------------
// vector_reflect_bounce
// Reflects vector A about normal N in fixed point, plain or damped bounce mode.
// ----------------------------------------------------------------------------
`include "vector_reflect_bounce_macros.svh"

module vector_reflect_bounce (
  input  logic                         clk,
  input  logic                         rst,
  vrb_in_if.sink                       vin,
  vrb_out_if.source                    vout,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vrb_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [1:0]  status;
  } res_t;

  // ---------------- configuration ----------------
  logic [vrb_pkg::DAMP_W-1:0] damping;
  logic [0:0]                 reg_idx;

  assign reg_idx = paddr[2:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= vrb_pkg::DAMP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        vrb_pkg::REG_DAMPING: damping <= pwdata[vrb_pkg::DAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vrb_pkg::REG_DAMPING: prdata = 32'(damping);
      default:              prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt;
  logic       en;

  assign en        = (cnt != 2'd2);
  assign vin.ready = en;

  // ---------------- stage 1: split signs and magnitudes ----------------
  logic [2:0][31:0] a_in, n_in;
  logic             v1, b1;
  logic [2:0][31:0] a1, am1, nm1;
  logic [2:0]       sx1, nn1;

  assign a_in = {vin.az, vin.ay, vin.ax};
  assign n_in = {vin.nz, vin.ny, vin.nx};

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= vin.bounce;
      for (int j = 0; j < 3; j++) begin
        a1[j]  <= a_in[j];
        am1[j] <= a_in[j][31] ? 32'(~a_in[j] + 32'd1) : a_in[j];
        nm1[j] <= n_in[j][31] ? 32'(~n_in[j] + 32'd1) : n_in[j];
        sx1[j] <= a_in[j][31] ^ n_in[j][31];
        nn1[j] <= n_in[j][31];
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic             v2, b2;
  logic [2:0][63:0] prod2, sq2;
  logic [2:0][31:0] a2, nm2;
  logic [2:0]       sx2, nn2;

  always_ff @(posedge clk) begin
    if (en) begin
      b2  <= b1;
      a2  <= a1;
      nm2 <= nm1;
      sx2 <= sx1;
      nn2 <= nn1;
      for (int j = 0; j < 3; j++) begin
        prod2[j] <= am1[j] * nm1[j];
        sq2[j]   <= nm1[j] * nm1[j];
      end
    end
  end

  // ---------------- stage 3: dot products ----------------
  logic             v3, b3;
  logic [63:0]      s3, pos3, neg3;
  logic [2:0][31:0] a3, nm3;
  logic [2:0]       nn3;

  always_ff @(posedge clk) begin
    if (en) begin
      b3   <= b2;
      a3   <= a2;
      nm3  <= nm2;
      nn3  <= nn2;
      s3   <= sq2[0] + sq2[1] + sq2[2];
      pos3 <= (sx2[0] ? 64'd0 : prod2[0]) + (sx2[1] ? 64'd0 : prod2[1])
            + (sx2[2] ? 64'd0 : prod2[2]);
      neg3 <= (sx2[0] ? prod2[0] : 64'd0) + (sx2[1] ? prod2[1] : 64'd0)
            + (sx2[2] ? prod2[2] : 64'd0);
    end
  end

  // ---------------- stage 4: signed A.N ----------------
  logic             v4, b4, dneg4, zero4;
  logic [63:0]      s4, dmag4;
  logic [2:0][31:0] a4, nm4;
  logic [2:0]       nn4;
  logic [64:0]      dp3, dn3;

  assign dp3 = {1'b0, pos3} - {1'b0, neg3};
  assign dn3 = {1'b0, neg3} - {1'b0, pos3};

  always_ff @(posedge clk) begin
    if (en) begin
      b4    <= b3;
      a4    <= a3;
      nm4   <= nm3;
      nn4   <= nn3;
      s4    <= s3;
      zero4 <= (s3 == 64'd0);
      dneg4 <= dp3[64];
      dmag4 <= dp3[64] ? dn3[63:0] : dp3[63:0];
    end
  end

  // ---------------- stage 5: 2*n*dot partial products ----------------
  logic             v5, b5, zero5;
  logic [63:0]      s5;
  logic [2:0][64:0] pl5, ph5;
  logic [2:0][31:0] a5;
  logic [2:0]       tpn5;

  always_ff @(posedge clk) begin
    if (en) begin
      b5    <= b4;
      a5    <= a4;
      s5    <= s4;
      zero5 <= zero4;
      for (int j = 0; j < 3; j++) begin
        pl5[j]  <= {nm4[j], 1'b0} * dmag4[31:0];
        ph5[j]  <= {nm4[j], 1'b0} * dmag4[63:32];
        tpn5[j] <= nn4[j] ^ dneg4;
      end
    end
  end

  // ---------------- stage 6: rounded numerator ----------------
  logic                              v6, b6, zero6;
  logic [63:0]                       s6;
  logic [2:0][vrb_pkg::NUM_W-1:0]    num6;
  logic [2:0][31:0]                  a6;
  logic [2:0]                        tpn6;

  always_ff @(posedge clk) begin
    if (en) begin
      b6    <= b5;
      a6    <= a5;
      s6    <= s5;
      zero6 <= zero5;
      tpn6  <= tpn5;
      for (int j = 0; j < 3; j++) begin
        num6[j] <= vrb_pkg::NUM_W'(pl5[j]) + vrb_pkg::NUM_W'({ph5[j], 32'd0})
                 + vrb_pkg::NUM_W'(s5[63:1]);
      end
    end
  end

  // ---------------- stage 7: quotient range check, divider load ----------------
  logic                              v7;
  logic [63:0]                       s7;
  logic [2:0][63:0]                  rem7;
  logic [2:0][vrb_pkg::QBITS-1:0]    low7;
  vrb_pkg::side_t                    side7;

  always_ff @(posedge clk) begin
    logic ovf;
    if (en) begin
      s7           <= s6;
      side7.a      <= a6;
      side7.tp_neg <= tpn6;
      side7.bounce <= b6;
      side7.zero   <= zero6;
      for (int j = 0; j < 3; j++) begin
        ovf = ({30'd0, num6[j][vrb_pkg::NUM_W-1:vrb_pkg::QBITS]} >= s6);
        side7.ovf[j] <= ovf;
        rem7[j] <= ovf ? 64'd0 : 64'(num6[j][vrb_pkg::NUM_W-1:vrb_pkg::QBITS]);
        low7[j] <= num6[j][vrb_pkg::QBITS-1:0];
      end
    end
  end

  // ---------------- divider ----------------
  logic                              dv;
  logic [2:0][vrb_pkg::QBITS-1:0]    dq;
  vrb_pkg::side_t                    dside;

  vrb_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .s        (s7),
    .rem0     (rem7),
    .low      (low7),
    .side_in  (side7),
    .out_valid(dv),
    .q        (dq),
    .side_out (dside)
  );

  // ---------------- stage C: clamp quotient ----------------
  localparam logic [vrb_pkg::QBITS-1:0] QCLAMP = {1'b1, {(vrb_pkg::QBITS-1){1'b0}}};

  logic                              vc, bc, zc, anc;
  logic [2:0][vrb_pkg::QBITS-1:0]    qc;
  logic [2:0]                        qnc;
  logic [2:0][31:0]                  ac;

  always_ff @(posedge clk) begin
    if (en) begin
      bc  <= dside.bounce;
      zc  <= dside.zero;
      ac  <= dside.a;
      anc <= ~dside.bounce;
      for (int j = 0; j < 3; j++) begin
        qc[j]  <= (dside.ovf[j] || dq[j] > QCLAMP) ? QCLAMP : dq[j];
        qnc[j] <= dside.tp_neg[j] ^ dside.bounce;
      end
    end
  end

  // ---------------- stage N: apply signs to terms ----------------
  logic             vn, bn, zn;
  logic [2:0][64:0] qsn, asn;

  always_ff @(posedge clk) begin
    logic [64:0] qe, ae;
    if (en) begin
      bn <= bc;
      zn <= zc;
      for (int j = 0; j < 3; j++) begin
        qe = {2'b00, qc[j]};
        ae = {{33{ac[j][31]}}, ac[j]};
        qsn[j] <= qnc[j] ? 65'(~qe + 65'd1) : qe;
        asn[j] <= anc    ? 65'(~ae + 65'd1) : ae;
      end
    end
  end

  // ---------------- stage V: difference ----------------
  logic             vv, bv, zv;
  logic [2:0][64:0] dv_v;

  always_ff @(posedge clk) begin
    if (en) begin
      bv <= bn;
      zv <= zn;
      for (int j = 0; j < 3; j++) begin
        dv_v[j] <= qsn[j] + asn[j];
      end
    end
  end

  // ---------------- stage M: magnitude ----------------
  logic             vm, bm, zm;
  logic [2:0]       negm;
  logic [2:0][62:0] magm;

  always_ff @(posedge clk) begin
    if (en) begin
      bm <= bv;
      zm <= zv;
      for (int j = 0; j < 3; j++) begin
        negm[j] <= dv_v[j][64];
        magm[j] <= dv_v[j][64] ? 63'(~dv_v[j] + 65'd1) : dv_v[j][62:0];
      end
    end
  end

  // ---------------- stage P: damping partial products ----------------
  logic             vp, bp, zp;
  logic [2:0]       negp;
  logic [2:0][62:0] magp;
  logic [2:0][48:0] blp;
  logic [2:0][47:0] bhp;

  always_ff @(posedge clk) begin
    if (en) begin
      bp   <= bm;
      zp   <= zm;
      negp <= negm;
      magp <= magm;
      for (int j = 0; j < 3; j++) begin
        blp[j] <= magm[j][31:0] * damping;
        bhp[j] <= magm[j][62:32] * damping;
      end
    end
  end

  // ---------------- stage R: scaled and rounded magnitude ----------------
  localparam logic [80:0] RND = 81'(1) << (vrb_pkg::FRAC_BITS - 1);

  logic             vr, zr;
  logic [2:0]       negr;
  logic [2:0][63:0] mr;

  always_ff @(posedge clk) begin
    logic [80:0] sum;
    if (en) begin
      zr   <= zp;
      negr <= negp;
      for (int j = 0; j < 3; j++) begin
        sum = 81'(blp[j]) + 81'({bhp[j], 32'd0}) + RND;
        mr[j] <= bp ? 64'(sum >> vrb_pkg::FRAC_BITS) : 64'(magp[j]);
      end
    end
  end

  // ---------------- stage S: saturate ----------------
  logic             vs, zs;
  logic [2:0]       negs, sats;
  logic [2:0][31:0] mags;

  always_ff @(posedge clk) begin
    logic        ng;
    logic [63:0] lim;
    if (en) begin
      zs <= zr;
      for (int j = 0; j < 3; j++) begin
        ng  = negr[j] && (mr[j] != 64'd0);
        lim = ng ? 64'h8000_0000 : 64'h7FFF_FFFF;
        negs[j] <= ng;
        sats[j] <= (mr[j] > lim);
        mags[j] <= (mr[j] > lim) ? lim[31:0] : mr[j][31:0];
      end
    end
  end

  // ---------------- stage F: final sign and status ----------------
  logic vf;
  res_t resf;

  always_ff @(posedge clk) begin
    logic [2:0][31:0] r;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r[j] = zs ? 32'd0 : (negs[j] ? 32'(~mags[j] + 32'd1) : mags[j]);
      end
      resf.rx <= r[0];
      resf.ry <= r[1];
      resf.rz <= r[2];
      resf.status <= zs ? vrb_pkg::STATUS_ZERO
                        : ((|sats) ? vrb_pkg::STATUS_SAT : vrb_pkg::STATUS_OK);
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
      {vc, vn, vv, vm, vp, vr, vs, vf} <= '0;
    end else if (en) begin
      v1 <= vin.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vc <= dv;
      vn <= vc;
      vv <= vn;
      vm <= vv;
      vp <= vm;
      vr <= vp;
      vs <= vr;
      vf <= vs;
    end
  end

  // ---------------- output buffer ----------------
  res_t fifo [2];
  logic wptr, rptr;
  logic push, pop;

  assign push = vf && en;
  assign pop  = vout.valid && vout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= resf;
    end
  end

  assign vout.valid  = (cnt != 2'd0);
  assign vout.rx     = fifo[rptr].rx;
  assign vout.ry     = fifo[rptr].ry;
  assign vout.rz     = fifo[rptr].rz;
  assign vout.status = fifo[rptr].status;

  // ---------------- assertions ----------------
  logic zero_beat;

  assign zero_beat = vout.valid && (vout.status == vrb_pkg::STATUS_ZERO);

  `VRB_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= 2'd2)
  `VRB_ASSERT_IMP(a_zero_result, zero_beat, {vout.rx, vout.ry, vout.rz} == 96'd0)
  `VRB_ASSERT_NEXT(a_stall_hold, !en, vf == $past(vf) && resf == $past(resf))
  `VRB_ASSERT_IMP(a_status_code, vout.valid, vout.status <= vrb_pkg::STATUS_SAT)

endmodule

// ===== tb/vrb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrb_checker
// Watches the vector and result channels and predicts each reflected vector.
// Every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vrb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] ax,
  input  logic [31:0] ay,
  input  logic [31:0] az,
  input  logic [31:0] nx,
  input  logic [31:0] ny,
  input  logic [31:0] nz,
  input  logic        bounce,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] rx,
  input  logic [31:0] ry,
  input  logic [31:0] rz,
  input  logic [1:0]  status,
  input  logic        damp_we,
  input  logic [16:0] damp_wdata,
  output int          errors,
  output int          pending,
  output int          beats_out,
  output int          sat_seen,
  output int          zero_seen
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
  } refl_t;

  refl_t                      refl_q[$];
  logic [vrb_pkg::DAMP_W-1:0] damping;

  // Signed 32-bit saturation of a wide signed value
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Predict one reflected vector; each quotient rounds to nearest, ties away from zero
  function automatic refl_t reflect(input logic [31:0] a[3], input logic [31:0] n[3],
                                    input logic bmode,
                                    input logic [vrb_pkg::DAMP_W-1:0] dmp);
    logic signed [127:0] dot, nn, mag, q, tp, v, m;
    logic                sat;
    logic [31:0]         r[3];
    refl_t               res;
    dot = 0;
    nn  = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dot += $signed(a[i]) * $signed(n[i]);
      nn  += $signed(n[i]) * $signed(n[i]);
    end
    if (nn == 0) begin
      res = '{32'd0, 32'd0, 32'd0, vrb_pkg::STATUS_ZERO};
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      mag = 2 * $signed(n[i]) * dot;
      if (mag < 0) mag = -mag;
      q = (mag + (nn >>> 1)) / nn;
      if (q > (128'sd1 <<< 62)) q = 128'sd1 <<< 62;
      tp = (($signed(n[i]) < 0) != (dot < 0)) ? -q : q;
      if (bmode) begin
        v = $signed(a[i]) - tp;
        m = ((v < 0 ? -v : v) * $signed({1'b0, dmp})
             + (128'sd1 <<< (vrb_pkg::FRAC_BITS - 1))) >>> vrb_pkg::FRAC_BITS;
        if (v < 0) m = -m;
      end else begin
        m = tp - $signed(a[i]);
      end
      r[i] = clamp32(m, sat);
    end
    res = '{r[0], r[1], r[2], sat ? vrb_pkg::STATUS_SAT : vrb_pkg::STATUS_OK};
    return res;
  endfunction

  // Report one mismatch and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [31:0] av[3], nv[3];
    refl_t       want;
    if (rst) begin
      damping   <= vrb_pkg::DAMP_RESET;
      errors    = 0;
      beats_out = 0;
      sat_seen  = 0;
      zero_seen = 0;
      refl_q.delete();
    end else begin
      // Predict with the damping in force before this edge's write
      if (in_valid && in_ready) begin
        av = '{ax, ay, az};
        nv = '{nx, ny, nz};
        refl_q.push_back(reflect(av, nv, bounce, damping));
      end
      if (damp_we) damping <= damp_wdata;
      // Compare the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        beats_out++;
        if (status == vrb_pkg::STATUS_SAT) sat_seen++;
        if (status == vrb_pkg::STATUS_ZERO) zero_seen++;
        if (refl_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          errors++;
        end else begin
          want = refl_q.pop_front();
          if (rx !== want.x) report_mismatch("rx", rx, want.x);
          if (ry !== want.y) report_mismatch("ry", ry, want.y);
          if (rz !== want.z) report_mismatch("rz", rz, want.z);
          if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
        end
      end
    end
    pending = refl_q.size();
  end
endmodule

// ===== tb/tb_vector_reflect_bounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_reflect_bounce
// Drives directed and random vector/normal pairs through the reflection block
// under several damping settings and idle patterns; the checker compares.
// ----------------------------------------------------------------------------
module tb_vector_reflect_bounce;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [vrb_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int   errors, pending, beats_out, sat_seen, zero_seen;
  int   cycles;
  int   send_idle_pct, recv_stall_pct;
  int   sent;

  vrb_in_if  vin();
  vrb_out_if vout();

  vector_reflect_bounce dut (
    .clk(clk), .rst(rst), .vin(vin.sink), .vout(vout.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vrb_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(vin.valid), .in_ready(vin.ready),
    .ax(vin.ax), .ay(vin.ay), .az(vin.az), .nx(vin.nx), .ny(vin.ny), .nz(vin.nz),
    .bounce(vin.bounce),
    .out_valid(vout.valid), .out_ready(vout.ready),
    .rx(vout.rx), .ry(vout.ry), .rz(vout.rz), .status(vout.status),
    .damp_we(psel && penable && pwrite && pready && paddr[2] == vrb_pkg::REG_DAMPING),
    .damp_wdata(pwdata[vrb_pkg::DAMP_W-1:0]),
    .errors(errors), .pending(pending), .beats_out(beats_out),
    .sat_seen(sat_seen), .zero_seen(zero_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: bound the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall at the phase's rate, decided at each falling edge
  always @(negedge clk) begin
    if (rst) vout.ready <= 1'b0;
    else vout.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Write the damping register with a setup and an access cycle
  task automatic write_damping(input logic [31:0] val);
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {vrb_pkg::REG_DAMPING, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, drain all predictions, then let the pipeline settle
  task automatic drain_results();
    vin.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Present one beat and hold it until accepted
  task automatic send_vector(input logic [31:0] a0, a1, a2, n0, n1, n2, input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      vin.valid <= 1'b0;
      @(negedge clk);
    end
    vin.valid  <= 1'b1;
    vin.ax     <= a0;
    vin.ay     <= a1;
    vin.az     <= a2;
    vin.nx     <= n0;
    vin.ny     <= n1;
    vin.nz     <= n2;
    vin.bounce <= b;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return 32'd0;
      default: return 32'($signed($urandom_range(4194304)) - 2097152);
    endcase
  endfunction

  task automatic random_vectors(input int count);
    logic [31:0] n0, n1, n2;
    for (int i = 0; i < count; i++) begin
      n0 = rand_comp();
      n1 = rand_comp();
      n2 = rand_comp();
      if ($urandom_range(49) == 0) begin
        n0 = 0; n1 = 0; n2 = 0;
      end
      send_vector(rand_comp(), rand_comp(), rand_comp(), n0, n1, n2,
                  1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [31:0] damp_set[5];
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    vin.valid = 1'b0; vin.ax = '0; vin.ay = '0; vin.az = '0;
    vin.nx = '0; vin.ny = '0; vin.nz = '0; vin.bounce = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero normal, A along N, both modes
    for (int b = 0; b < 2; b++) begin
      send_vector(32'h10000, 0, 0, 32'h10000, 0, 0, 1'(b));
      send_vector(32'h10000, 32'h20000, 0, 0, 0, 0, 1'(b));
      send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'(b));
      send_vector(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000, 1'(b));
      send_vector(32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 32'h0, 32'h0, 1'(b));
      send_vector(32'h80000000, 32'h7FFFFFFF, 0, 32'h1, 32'h1, 32'h0, 1'(b));
      send_vector(32'h8000, 32'hFFFF8000, 32'h3, 32'h1, 32'hFFFFFFFF, 32'h1, 1'(b));
      send_vector(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1, 1'(b));
      send_vector(32'h10000, 32'h10000, 0, 0, 32'hFFFF0000, 0, 1'(b));
      send_vector(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                  32'h3, 32'h5, 32'h7, 1'(b));
    end

    // Phases: damping setting crossed with idle pattern
    damp_set = '{32'd65536, 32'd0, 32'd32768, 32'h1FFFF, 32'd1};
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_damping(damp_set[p]);
      send_idle_pct  = (p == 1 || p == 4) ? 84 : (p == 3 ? 33 : 0);
      recv_stall_pct = (p == 2 || p == 4) ? 84 : (p == 3 ? 33 : 0);
      random_vectors(p == 4 ? 170 : 420);
      // Hold the sender until every result is back, then resume
      if (p == 0) begin
        vin.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        random_vectors(30);
      end
    end

    drain_results();
    $display("sent %0d vector beats, checked %0d results (%0d zero-normal, %0d saturated)",
             sent, beats_out, zero_seen, sat_seen);
    $display("damping covered 0, 1 lsb, 0.5, 1.0 and max, under five idle patterns");
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vrb_pkg.sv
hw/rtl/vrb_if.sv
hw/rtl/vrb_divider.sv
hw/rtl/vector_reflect_bounce.sv
tb/vrb_checker.sv
tb/tb_vector_reflect_bounce.sv
